@@ sv/modexp_pkg.sv @@
`timescale 1ns / 1ps

package modexp_pkg;

    localparam int WIDTH = 32;
    localparam int IO_W  = 32;
    localparam int CNT_W = $clog2(WIDTH);
    localparam int ST_W  = 3;

    typedef logic [WIDTH-1:0] t_word;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
        t_word m;
    } t_mm_req;

    typedef struct packed {
        logic  done;
        t_word r;
    } t_mm_rsp;

endpackage

@@ sv/modular_exponentiation.sv @@
`timescale 1ns / 1ps

// Right-to-left binary modular exponentiation: o_power = i_base ^ i_exponent mod i_modulus,
// one request at a time. All modular products go through one bit-serial multiply-reduce
// unit. A request costs one product to reduce the base, one squaring per exponent bit
// and one extra product per set exponent bit. A zero modulus finishes with o_power = 0
// and o_bad_modulus set. o_stall stays high while a request is being worked on; a
// finished result sits in an output register.
module modular_exponentiation (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [modexp_pkg::IO_W-1:0] i_base,
    input  logic [modexp_pkg::IO_W-1:0] i_exponent,
    input  logic [modexp_pkg::IO_W-1:0] i_modulus,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [modexp_pkg::IO_W-1:0] o_power,
    output logic                        o_bad_modulus
);
    import modexp_pkg::*;

    localparam logic [ST_W-1:0] S_IDLE = 3'd0;
    localparam logic [ST_W-1:0] S_RED  = 3'd1;
    localparam logic [ST_W-1:0] S_MUL  = 3'd2;
    localparam logic [ST_W-1:0] S_SQR  = 3'd3;
    localparam logic [ST_W-1:0] S_OUT  = 3'd4;

    localparam t_cnt  LAST = CNT_W'(WIDTH - 1);
    localparam t_word ONE  = WIDTH'(1);

    logic [ST_W-1:0] r_state, n_state;
    t_word           r_e, n_e;
    t_word           r_m, n_m;
    t_word           r_acc, n_acc;
    t_word           r_sq, n_sq;
    t_cnt            r_idx, n_idx;
    logic            r_bad, n_bad;
    t_mm_req         r_req, n_req;
    logic            r_out_valid;
    t_word           r_power;
    logic            r_out_bad;
    t_mm_rsp         mm_rsp;
    logic            in_acc;
    logic            out_load;

    modexp_mulmod u_mulmod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_req),
        .o_rsp  (mm_rsp)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state   = r_state;
        n_e       = r_e;
        n_m       = r_m;
        n_acc     = r_acc;
        n_sq      = r_sq;
        n_idx     = r_idx;
        n_bad     = r_bad;
        n_req     = r_req;
        n_req.start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_e   = i_exponent[WIDTH-1:0];
                    n_m   = i_modulus[WIDTH-1:0];
                    n_idx = '0;
                    n_acc = (i_modulus[WIDTH-1:0] == ONE) ? '0 : ONE;
                    if (i_modulus[WIDTH-1:0] == '0) begin
                        n_bad   = 1'b1;
                        n_acc   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_bad       = 1'b0;
                        n_req.start = 1'b1;
                        n_req.a     = i_base[WIDTH-1:0];
                        n_req.b     = ONE;
                        n_req.m     = i_modulus[WIDTH-1:0];
                        n_state     = S_RED;
                    end
                end
            end
            S_RED, S_SQR: begin
                if (mm_rsp.done) begin
                    n_sq = mm_rsp.r;
                    if (r_state == S_SQR) begin
                        n_e   = r_e >> 1;
                        n_idx = r_idx + 1'b1;
                    end
                    if (r_state == S_SQR && r_idx == LAST) begin
                        n_state = S_OUT;
                    end else if (n_e[0]) begin
                        n_req.start = 1'b1;
                        n_req.a     = r_acc;
                        n_req.b     = mm_rsp.r;
                        n_req.m     = r_m;
                        n_state     = S_MUL;
                    end else begin
                        n_req.start = 1'b1;
                        n_req.a     = mm_rsp.r;
                        n_req.b     = mm_rsp.r;
                        n_req.m     = r_m;
                        n_state     = S_SQR;
                    end
                end
            end
            S_MUL: begin
                if (mm_rsp.done) begin
                    n_acc       = mm_rsp.r;
                    n_req.start = 1'b1;
                    n_req.a     = r_sq;
                    n_req.b     = r_sq;
                    n_req.m     = r_m;
                    n_state     = S_SQR;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req.start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req       <= n_req;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e     <= n_e;
        r_m     <= n_m;
        r_acc   <= n_acc;
        r_sq    <= n_sq;
        r_idx   <= n_idx;
        r_bad   <= n_bad;
        if (out_load) begin
            r_power   <= r_acc;
            r_out_bad <= r_bad;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_power       = IO_W'(r_power);
    assign o_bad_modulus = r_out_bad;

endmodule

@@ sv/modexp_mulmod.sv @@
`timescale 1ns / 1ps

module modexp_mulmod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  modexp_pkg::t_mm_req i_req,
    output modexp_pkg::t_mm_rsp o_rsp
);
    import modexp_pkg::*;

    localparam t_cnt LAST = CNT_W'(WIDTH - 1);

    t_word            r_a;
    t_word            r_b;
    t_word            r_m;
    t_word            r_r;
    t_cnt             r_cnt;
    logic             r_busy;
    logic             r_done;
    t_word            n_r;
    logic [WIDTH+1:0] t;
    logic [WIDTH+1:0] m1;
    logic [WIDTH+1:0] m2;

    // interleaved multiply-reduce, a scanned MSB first: r = 2r + a_i*b mod m
    always_comb begin
        m1 = {2'b00, r_m};
        m2 = {1'b0, r_m, 1'b0};
        t  = {1'b0, r_r, 1'b0} + (r_a[WIDTH-1] ? {2'b00, r_b} : '0);
        if (t >= m2) begin
            n_r = WIDTH'(t - m2);
        end else if (t >= m1) begin
            n_r = WIDTH'(t - m1);
        end else begin
            n_r = WIDTH'(t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == LAST);
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_m    <= i_req.m;
                r_r    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_r   <= n_r;
                r_a   <= r_a << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.r    = r_r;

endmodule

@@ bench/modular_exponentiation_tb.sv @@
`timescale 1ns / 1ps

module modular_exponentiation_tb;

    import modexp_pkg::*;

    localparam int W          = modexp_pkg::WIDTH;
    localparam int RAND_REQS  = 280;
    localparam int PHASE_LEN  = RAND_REQS / 4;
    localparam int DRAIN_CYC  = 2500;
    localparam int CYCLE_CAP  = 3_000_000;
    localparam int MAX_REPORT = 10;

    typedef logic [modexp_pkg::IO_W-1:0] t_io_word;

    typedef enum logic [1:0] {
        PH_FLAT,
        PH_SEND_GAPS,
        PH_RECV_STALLS,
        PH_MIXED
    } t_phase;

    typedef struct {
        t_io_word base;
        t_io_word exponent;
        t_io_word modulus;
        t_phase   phase;
    } t_request;

    typedef struct {
        t_io_word power;
        logic     bad_modulus;
    } t_power;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_io_word i_base;
    t_io_word i_exponent;
    t_io_word i_modulus;
    logic     o_valid;
    logic     i_stall;
    t_io_word o_power;
    logic     o_bad_modulus;

    t_request req_q[$];
    t_power   power_q[$];
    t_request nxt_req;
    t_power   want;
    t_phase   cur_phase;
    logic     req_fire;
    int       total_reqs;
    int       accepted_cnt;
    int       fail_cnt;
    int       cycle_cnt;

    modular_exponentiation u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_base        (i_base),
        .i_exponent    (i_exponent),
        .i_modulus     (i_modulus),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_power       (o_power),
        .o_bad_modulus (o_bad_modulus)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // right-to-left square and multiply, double-width products
    function automatic t_power calc_power(t_io_word b, t_io_word e, t_io_word m);
        logic [2*W-1:0] prod;
        t_word          acc;
        t_word          sq;
        t_word          md;
        t_word          ex;
        t_power         res;
        md              = m[W-1:0];
        ex              = e[W-1:0];
        res.bad_modulus = (md == '0);
        res.power       = '0;
        if (md != '0) begin
            acc = (md == t_word'(1)) ? '0 : t_word'(1);
            sq  = b[W-1:0] % md;
            for (int i = 0; i < W; i++) begin
                if (ex[i]) begin
                    prod = {{W{1'b0}}, acc} * {{W{1'b0}}, sq};
                    acc  = t_word'(prod % {{W{1'b0}}, md});
                end
                prod = {{W{1'b0}}, sq} * {{W{1'b0}}, sq};
                sq   = t_word'(prod % {{W{1'b0}}, md});
            end
            res.power[W-1:0] = acc;
        end
        return res;
    endfunction

    function automatic int gap_pct(t_phase ph);
        case (ph)
            PH_SEND_GAPS: return 70;
            PH_MIXED:     return 31;
            default:      return 0;
        endcase
    endfunction

    function automatic int stall_pct(t_phase ph);
        case (ph)
            PH_RECV_STALLS: return 70;
            PH_MIXED:       return 31;
            default:        return 0;
        endcase
    endfunction

    task automatic add_req(t_io_word b, t_io_word e, t_io_word m, t_phase ph);
        t_request r;
        r.base     = b;
        r.exponent = e;
        r.modulus  = m;
        r.phase    = ph;
        req_q.insert(req_q.size(), r);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct(cur_phase));
            if (!i_valid || req_fire) begin
                if (req_q.size() != 0 && $urandom_range(99) >= gap_pct(req_q[0].phase)) begin
                    nxt_req    = req_q.pop_front();
                    cur_phase  = nxt_req.phase;
                    i_base     <= nxt_req.base;
                    i_exponent <= nxt_req.exponent;
                    i_modulus  <= nxt_req.modulus;
                    i_valid    <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check results, then record newly accepted requests
    always @(posedge i_clk) begin
        req_fire <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (power_q.size() == 0) begin
                    if (fail_cnt < MAX_REPORT)
                        $display("unexpected result: power=%h bad_modulus=%b",
                                 o_power, o_bad_modulus);
                    fail_cnt++;
                end else begin
                    want = power_q.pop_front();
                    if (o_power !== want.power || o_bad_modulus !== want.bad_modulus) begin
                        if (fail_cnt < MAX_REPORT)
                            $display("mismatch: power exp %h got %h, bad_modulus exp %b got %b",
                                     want.power, o_power, want.bad_modulus, o_bad_modulus);
                        fail_cnt++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                power_q.insert(power_q.size(), calc_power(i_base, i_exponent, i_modulus));
                accepted_cnt++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP) begin
            $display("modular_exponentiation_tb: FAIL");
            $finish;
        end
    end

    initial begin
        t_io_word b;
        t_io_word e;
        t_io_word m;
        t_phase   ph;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_base       = '0;
        i_exponent   = '0;
        i_modulus    = '0;
        req_fire     = 1'b0;
        cur_phase    = PH_FLAT;
        accepted_cnt = 0;
        fail_cnt     = 0;
        cycle_cnt    = 0;

        // zero modulus
        add_req(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, PH_FLAT);
        add_req(32'h0000_0005, 32'h0000_0003, 32'h0000_0000, PH_FLAT);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, PH_FLAT);
        // modulus of one
        add_req(32'h0000_0007, 32'h0000_0000, 32'h0000_0001, PH_FLAT);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, PH_FLAT);
        // zero exponent, then other edge cases
        add_req(32'h0000_0000, 32'h0000_0000, 32'h0000_0005, PH_FLAT);
        add_req(32'h0000_0009, 32'h0000_0000, 32'h0000_0007, PH_FLAT);
        add_req(32'h0000_0000, 32'h0000_0005, 32'h0000_000D, PH_FLAT);
        add_req(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PH_FLAT);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PH_FLAT);
        add_req(32'hFFFF_FFFE, 32'h0000_0002, 32'hFFFF_FFFF, PH_FLAT);
        add_req(32'h0000_0002, 32'h0000_000A, 32'h0000_03E8, PH_FLAT);
        // 3^(p-1) mod p = 1 for the largest 32-bit prime
        add_req(32'h0000_0003, 32'hFFFF_FFFA, 32'hFFFF_FFFB, PH_FLAT);
        add_req(32'hDEAD_BEEF, 32'h0000_0001, 32'h0001_0000, PH_FLAT);
        add_req(32'h0000_3039, 32'h0000_0007, 32'h0000_3039, PH_FLAT);
        add_req(32'h0000_0002, 32'h0000_001F, 32'h8000_0000, PH_FLAT);
        add_req(32'h0000_0002, 32'h0000_0020, 32'h8000_0000, PH_FLAT);
        add_req(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, PH_FLAT);
        add_req(32'h0000_0005, 32'h0000_0002, 32'h0000_0002, PH_FLAT);
        add_req(32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF, PH_FLAT);

        for (int i = 0; i < RAND_REQS; i++) begin
            ph = t_phase'(i / PHASE_LEN);
            case ($urandom_range(19))
                0:       m = '0;
                1:       m = 32'd1;
                2:       m = 32'hFFFF_FFFF;
                3, 4:    m = $urandom_range(255);
                5:       m = $urandom_range(65535, 2);
                default: m = $urandom;
            endcase
            case ($urandom_range(9))
                0:       e = $urandom_range(15);
                1:       e = 32'hFFFF_FFFF;
                2:       e = 32'd1 << $urandom_range(31);
                default: e = $urandom;
            endcase
            case ($urandom_range(11))
                0:       b = '0;
                1:       b = 32'd1;
                2:       b = 32'hFFFF_FFFF;
                3:       b = m - 32'd1;
                4:       b = m;
                default: b = $urandom;
            endcase
            add_req(b, e, m, ph);
        end
        total_reqs = req_q.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt < total_reqs || power_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (fail_cnt == 0 && power_q.size() == 0) begin
            $display("modular_exponentiation_tb: PASS");
        end else begin
            $display("modular_exponentiation_tb: FAIL");
        end
        $finish;
    end

endmodule
